/* rtl/pts_pkg.sv */
// ============================================================================
// pts_pkg - projectile slot table shared definitions
// Command and result codes, controller states, and the controller/datapath
// command and status bundles.
// ============================================================================
`default_nettype none

package pts_pkg;

  // Input commands
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Result kinds
  localparam logic [2:0] K_ADDED   = 3'd0;
  localparam logic [2:0] K_FULL    = 3'd1;
  localparam logic [2:0] K_MOVED   = 3'd2;
  localparam logic [2:0] K_OFF     = 3'd3;
  localparam logic [2:0] K_REMOVED = 3'd4;
  localparam logic [2:0] K_EMPTY   = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_X_MIN = 2'd0;
  localparam logic [1:0] CFG_Y_MIN = 2'd1;
  localparam logic [1:0] CFG_X_MAX = 2'd2;
  localparam logic [1:0] CFG_Y_MAX = 2'd3;

  localparam int SLOT_W = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_RD,
    S_EVAL,
    S_END
  } state_t;

  // Source of the value loaded into the output register
  typedef enum logic [2:0] {
    RES_ADDED,
    RES_FULL,
    RES_RM_HIT,
    RES_RM_MISS,
    RES_PEND,
    RES_EMPTY
  } res_sel_t;

  typedef struct packed {
    logic     cap;
    logic     idx_clr;
    logic     idx_inc;
    logic     add_wr;
    logic     rm_clr;
    logic     tick_wr;
    logic     out_load;
    res_sel_t out_sel;
    logic     out_last;
    logic     pend_clr;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       valid_cur;
    logic       idx_last;
    logic       match;
    logic       pend_valid;
    logic       out_free;
  } stat_t;

  typedef struct packed {
    logic [7:0] sprite;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] vel_x;
    logic [7:0] vel_y;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/pts_ctrl.sv */
// ============================================================================
// pts_ctrl - projectile slot table controller
// Walks the slot index for add, remove and tick, and sequences the results.
// ============================================================================
`default_nettype none

module pts_ctrl
  import pts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  output logic       in_ready,
  input  stat_t      st,
  output ctl_t       ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.out_sel = RES_ADDED;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cap      = 1'b1;
          ctl.idx_clr  = 1'b1;
          ctl.pend_clr = 1'b1;
          case (cmd)
            CMD_ADD:    state_next = S_ADD;
            CMD_TICK:   state_next = S_RD;
            CMD_REMOVE: state_next = S_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (!st.valid_cur) begin
          if (st.out_free) begin
            ctl.add_wr   = 1'b1;
            ctl.out_load = 1'b1;
            ctl.out_sel  = RES_ADDED;
            ctl.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (st.idx_last) begin
          if (st.out_free) begin
            ctl.out_load = 1'b1;
            ctl.out_sel  = RES_FULL;
            ctl.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      // skip free slots; a busy slot is read and evaluated next cycle
      S_RD: begin
        if (st.valid_cur) begin
          state_next = S_EVAL;
        end else if (st.idx_last) begin
          state_next = S_END;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_EVAL: begin
        if (st.op == CMD_REMOVE) begin
          if (st.match) begin
            if (st.out_free) begin
              ctl.rm_clr   = 1'b1;
              ctl.out_load = 1'b1;
              ctl.out_sel  = RES_RM_HIT;
              ctl.out_last = 1'b1;
              state_next   = S_IDLE;
            end
          end else if (st.idx_last) begin
            state_next = S_END;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_RD;
          end
        end else begin
          // tick: previous result moves out, this one is held back
          if (!st.pend_valid || st.out_free) begin
            ctl.tick_wr = 1'b1;
            if (st.pend_valid) begin
              ctl.out_load = 1'b1;
              ctl.out_sel  = RES_PEND;
            end
            if (st.idx_last) begin
              state_next = S_END;
            end else begin
              ctl.idx_inc = 1'b1;
              state_next  = S_RD;
            end
          end
        end
      end
      S_END: begin
        if (st.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_last = 1'b1;
          if (st.op == CMD_REMOVE) begin
            ctl.out_sel = RES_RM_MISS;
          end else if (st.pend_valid) begin
            ctl.out_sel = RES_PEND;
          end else begin
            ctl.out_sel = RES_EMPTY;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pts_dpath.sv */
// ============================================================================
// pts_dpath - projectile slot table datapath
// Slot memory, valid bits, bound registers, tick arithmetic, held-back tick
// result and the output register.
// ============================================================================
`default_nettype none

module pts_dpath
  import pts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output stat_t             st,
  input  logic [1:0]        cmd,
  input  logic [7:0]        sprite_num,
  input  logic [7:0]        start_x,
  input  logic [7:0]        start_y,
  input  logic [7:0]        vel_x,
  input  logic [7:0]        vel_y,
  input  logic              cfg_wr,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [SLOT_W-1:0] slot,
  output logic [7:0]        sprite_out,
  output logic [7:0]        pos_x_out,
  output logic [7:0]        pos_y_out,
  output logic              last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [IDX_W-1:0]     idx;
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [1:0]           op;
  entry_t               cap;
  logic [7:0]           x_min, y_min, x_max, y_max;

  entry_t               mem [NUM_SLOTS];
  entry_t               rdata;
  entry_t               wr_data;
  logic                 wr_en;

  logic [7:0]           new_x, new_y;
  logic                 off;
  logic [SLOT_W-1:0]    idx_slot;

  logic                 pend_valid;
  logic [2:0]           pend_kind;
  logic [SLOT_W-1:0]    pend_slot;
  logic [7:0]           pend_sprite, pend_x, pend_y;

  logic [2:0]           res_kind;
  logic [SLOT_W-1:0]    res_slot;
  logic [7:0]           res_sprite, res_x, res_y;

  always_comb begin
    idx_slot = '0;
    idx_slot[IDX_W-1:0] = idx;
  end

  // index walk and command capture
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (ctl.idx_clr) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      op         <= cmd;
      cap.sprite <= sprite_num;
      cap.pos_x  <= start_x;
      cap.pos_y  <= start_y;
      cap.vel_x  <= vel_x;
      cap.vel_y  <= vel_y;
    end
  end

  // bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min <= 8'd0;
      y_min <= 8'd0;
      x_max <= 8'd127;
      y_max <= 8'd127;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_X_MIN: x_min <= cfg_data;
        CFG_Y_MIN: y_min <= cfg_data;
        CFG_X_MAX: x_max <= cfg_data;
        CFG_Y_MAX: y_max <= cfg_data;
        default:   x_min <= x_min;
      endcase
    end
  end

  // tick arithmetic on the entry read last cycle
  assign new_x = rdata.pos_x + rdata.vel_x;
  assign new_y = rdata.pos_y + rdata.vel_y;
  assign off   = ($signed(new_x) < $signed(x_min)) || ($signed(new_y) < $signed(y_min)) ||
                 ($signed(new_x) > $signed(x_max)) || ($signed(new_y) > $signed(y_max));

  always_comb begin
    wr_en   = ctl.add_wr || ctl.tick_wr;
    wr_data = cap;
    if (ctl.tick_wr) begin
      wr_data       = rdata;
      wr_data.pos_x = new_x;
      wr_data.pos_y = new_y;
    end
  end

  // slot memory: one write, one registered read at the walk index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_data;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctl.add_wr) begin
      slot_valid[idx] <= 1'b1;
    end else if (ctl.rm_clr || (ctl.tick_wr && off)) begin
      slot_valid[idx] <= 1'b0;
    end
  end

  // held-back tick result, so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (ctl.pend_clr) begin
      pend_valid <= 1'b0;
    end else if (ctl.tick_wr) begin
      pend_valid <= 1'b1;
    end else if (ctl.out_load && (ctl.out_sel == RES_PEND)) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick_wr) begin
      pend_kind   <= off ? K_OFF : K_MOVED;
      pend_slot   <= idx_slot;
      pend_sprite <= rdata.sprite;
      pend_x      <= new_x;
      pend_y      <= new_y;
    end
  end

  always_comb begin
    res_kind   = K_EMPTY;
    res_slot   = '0;
    res_sprite = cap.sprite;
    res_x      = '0;
    res_y      = '0;
    case (ctl.out_sel)
      RES_ADDED: begin
        res_kind = K_ADDED;
        res_slot = idx_slot;
      end
      RES_FULL: begin
        res_kind = K_FULL;
      end
      RES_RM_HIT: begin
        res_kind = K_REMOVED;
        res_slot = idx_slot;
      end
      RES_RM_MISS: begin
        res_kind = K_REMOVED;
      end
      RES_PEND: begin
        res_kind   = pend_kind;
        res_slot   = pend_slot;
        res_sprite = pend_sprite;
        res_x      = pend_x;
        res_y      = pend_y;
      end
      default: begin
        res_kind   = K_EMPTY;
        res_sprite = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      kind       <= res_kind;
      slot       <= res_slot;
      sprite_out <= res_sprite;
      pos_x_out  <= res_x;
      pos_y_out  <= res_y;
      last       <= ctl.out_last;
    end
  end

  assign st.op         = op;
  assign st.valid_cur  = slot_valid[idx];
  assign st.idx_last   = (idx == IDX_W'(NUM_SLOTS - 1));
  assign st.match      = (rdata.sprite == cap.sprite);
  assign st.pend_valid = pend_valid;
  assign st.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

/* rtl/projectile_slot_table.sv */
// ============================================================================
// projectile_slot_table - fixed table of projectile slots
// Add, remove and per-frame tick of projectiles with screen-bound culling.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: add, tick or
//   remove. Unused command 3 is taken and dropped with no result.
//   Output channel (out_valid/out_ready) returns result items; last marks the
//   final result of a command. Add, remove and empty tick give one result,
//   a tick gives one result per busy slot in ascending slot order.
//   Config channel (cfg_valid/cfg_ready, always ready) writes the bounds
//   x_min, y_min, x_max, y_max; write only while the table is idle.
// Timing:
//   Slots are visited by a single index over a slot memory with a
//   registered read port. Add tests each slot's valid bit in turn; remove
//   and tick visit a free slot in S_RD and a busy slot in S_RD then S_EVAL,
//   and a tick or a missed remove finishes in S_END. A new item is taken
//   the cycle after the last result is loaded, while that result may still
//   wait in the output register.
// Reset: all slots free, bounds 0..127. Slot contents are not cleared.
// Stall: a stalled receiver holds the output register; the walk pauses
//   whenever a result is ready but the output register is still full.
// ============================================================================
`default_nettype none

module projectile_slot_table
  import pts_pkg::*;
#(
  parameter int NUM_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        sprite_num,
  input  logic [7:0]        start_x,
  input  logic [7:0]        start_y,
  input  logic [7:0]        vel_x,
  input  logic [7:0]        vel_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [SLOT_W-1:0] slot,
  output logic [7:0]        sprite_out,
  output logic [7:0]        pos_x_out,
  output logic [7:0]        pos_y_out,
  output logic              last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data
);

  ctl_t  ctl;
  stat_t st;

  // bounds are plain registers, so a write is always accepted
  assign cfg_ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_ready (in_ready),
    .st       (st),
    .ctl      (ctl)
  );

  pts_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .st         (st),
    .cmd        (cmd),
    .sprite_num (sprite_num),
    .start_x    (start_x),
    .start_y    (start_y),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .slot       (slot),
    .sprite_out (sprite_out),
    .pos_x_out  (pos_x_out),
    .pos_y_out  (pos_y_out),
    .last       (last)
  );

  // a real command drops in_ready in the cycle after it is taken
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (cmd != CMD_UNUSED)) |=> !in_ready)
    else $error("table took a second item right after a command");

  // add, full and remove each produce a single, final result
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((kind == K_ADDED) || (kind == K_FULL) || (kind == K_REMOVED))) |-> last)
    else $error("single-result command without last");

  // empty tick is final and carries no slot, sprite or x position
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == K_EMPTY)) |->
      (last && (slot == '0) && (sprite_out == 8'd0) && (pos_x_out == 8'd0)))
    else $error("empty tick result not clean");

endmodule

`default_nettype wire
